### src/blie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_pkg: shared types and codes of the bounded indexed list engine
// Field widths, command and status codes, and the control word that the
// top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package blie_pkg;

   localparam int DATA_W           = 32;
   localparam int CMD_W            = 4;
   localparam int POS_W            = 5;
   localparam int STATUS_W         = 3;
   localparam int COUNT_OUT_W      = 5;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [DATA_W-1:0] NONE_WORD = '1;

   localparam logic [CMD_W-1:0] CMD_APPEND       = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PREPEND      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK     = 4'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 4'd3;
   localparam logic [CMD_W-1:0] CMD_GET          = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SET          = 4'd5;
   localparam logic [CMD_W-1:0] CMD_INSERT       = 4'd6;
   localparam logic [CMD_W-1:0] CMD_REMOVE_VALUE = 4'd7;
   localparam logic [CMD_W-1:0] CMD_REMOVE_INDEX = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic ins;
      logic del;
      logic set;
      logic by_value;
   } cell_op_type;

endpackage

### src/blie_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_cell: one list slot
// Holds one word and its occupancy bit. Shifts back on insert, front on
// delete, writes on set, and passes a first-match flag to the next slot.
// ----------------------------------------------------------------------------
module blie_cell
   import blie_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int TW    = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_op_type       op,
   input  logic [TW-1:0]     target,
   input  logic [DATA_W-1:0] data,
   input  logic [DATA_W-1:0] left_word,
   input  logic              left_valid,
   input  logic [DATA_W-1:0] right_word,
   input  logic              right_valid,
   input  logic              found_in,
   output logic [DATA_W-1:0] word,
   output logic              valid,
   output logic              found_out,
   output logic [DATA_W-1:0] pick
);

   localparam logic [TW-1:0] IDX = TW'(INDEX);

   logic [DATA_W-1:0] word_ff, word_in;
   logic              valid_ff, valid_in;
   logic              match;
   logic              at_or_after;
   logic              sel;

   assign match       = valid_ff && (word_ff == data);
   assign found_out   = found_in | match;
   assign at_or_after = op.by_value ? (found_in | match) : (IDX >= target);
   assign sel         = op.by_value ? (match & ~found_in) : (valid_ff && (IDX == target));
   assign pick        = sel ? word_ff : '0;
   assign word        = word_ff;
   assign valid       = valid_ff;

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      if (op.ins) begin
         if (IDX > target) begin
            word_in = left_word;
         end else if (IDX == target) begin
            word_in = data;
         end
         valid_in = valid_ff | left_valid;
      end else if (op.del) begin
         if (at_or_after) begin
            word_in = right_word;
         end
         valid_in = right_valid;
      end else if (op.set) begin
         if (IDX == target) begin
            word_in = data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

### src/bounded_indexed_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_indexed_list_engine_core: ordered list of signed words
// One command per cycle unless a response stalls: a command is taken on the
// transfer edge and its result is registered for the next cycle, with one
// response per command. The list lives in a row of CAPACITY slots; every
// slot shifts, writes or compares in the same cycle, whatever the
// position. Remove by value finds the first equal word through a match flag
// that passes from slot to slot. A new command is taken while the previous
// response waits, as long as that response is taken in the same cycle.
// ----------------------------------------------------------------------------
module bounded_indexed_list_engine_core
   import blie_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_data_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_result_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_OUT_W-1:0]     rsp_item_count,
   output logic                       rsp_is_empty
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int TW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      value_ff, value_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [COUNT_OUT_W-1:0] item_count_ff;
   logic                   is_empty_ff;

   logic                   accept;
   logic                   full;
   logic                   take_pick;
   logic [TW-1:0]          count_x, pos_x, count_in_x;
   logic [TW-1:0]          target;
   cell_op_type            op_raw, op;
   logic [DATA_W-1:0]      pick_or;

   logic [DATA_W-1:0]      words [CAPACITY];
   logic [DATA_W-1:0]      picks [CAPACITY];
   logic [CAPACITY-1:0]    valids;
   logic [CAPACITY:0]      found;

   assign accept    = req_valid & req_ready;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign full      = count_ff >= CW'(CAPACITY);
   assign count_x   = TW'(count_ff);
   assign pos_x     = TW'(req_position);
   assign found[0]  = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] lw, rw;
      logic              lv, rv;
      if (i == 0) begin : g_first
         assign lw = '0;
         assign lv = 1'b1;
      end else begin : g_inner_l
         assign lw = words[i-1];
         assign lv = valids[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rw = '0;
         assign rv = 1'b0;
      end else begin : g_inner_r
         assign rw = words[i+1];
         assign rv = valids[i+1];
      end
      blie_cell #(
         .INDEX (i),
         .TW    (TW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .target      (target),
         .data        (req_data_value),
         .left_word   (lw),
         .left_valid  (lv),
         .right_word  (rw),
         .right_valid (rv),
         .found_in    (found[i]),
         .word        (words[i]),
         .valid       (valids[i]),
         .found_out   (found[i+1]),
         .pick        (picks[i])
      );
   end

   always_comb begin
      pick_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pick_or = pick_or | picks[i];
      end
   end

   always_comb begin
      op_raw    = '0;
      target    = '0;
      status_in = ST_OK;
      take_pick = 1'b0;
      case (req_command)
         CMD_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op_raw.ins = 1'b1;
               target     = count_x;
            end
         end
         CMD_PREPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op_raw.ins = 1'b1;
            end
         end
         CMD_INSERT: begin
            target = pos_x;
            if (full) begin
               status_in = ST_FULL;
            end else if (pos_x > count_x) begin
               status_in = ST_RANGE;
            end else begin
               op_raw.ins = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            target = count_x - TW'(1);
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               op_raw.del = 1'b1;
               take_pick  = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               op_raw.del = 1'b1;
               take_pick  = 1'b1;
            end
         end
         CMD_GET: begin
            target = pos_x;
            if (pos_x >= count_x) begin
               status_in = ST_RANGE;
            end else begin
               take_pick = 1'b1;
            end
         end
         CMD_SET: begin
            target = pos_x;
            if (pos_x >= count_x) begin
               status_in = ST_RANGE;
            end else begin
               op_raw.set = 1'b1;
            end
         end
         CMD_REMOVE_INDEX: begin
            target = pos_x;
            if (pos_x >= count_x) begin
               status_in = ST_RANGE;
            end else begin
               op_raw.del = 1'b1;
               take_pick  = 1'b1;
            end
         end
         CMD_REMOVE_VALUE: begin
            op_raw.by_value = 1'b1;
            if (found[CAPACITY]) begin
               op_raw.del = 1'b1;
               take_pick  = 1'b1;
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      op          = op_raw;
      op.ins      = op_raw.ins & accept;
      op.del      = op_raw.del & accept;
      op.set      = op_raw.set & accept;
      count_in    = count_ff;
      if (op.ins) begin
         count_in = count_ff + CW'(1);
      end else if (op.del) begin
         count_in = count_ff - CW'(1);
      end
      count_in_x   = TW'(count_in);
      value_in     = take_pick ? pick_or : NONE_WORD;
      rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         value_ff      <= value_in;
         status_ff     <= status_in;
         item_count_ff <= count_in_x[COUNT_OUT_W-1:0];
         is_empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_item_count   = item_count_ff;
   assign rsp_is_empty     = is_empty_ff;

endmodule

### src/blie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blie_checker: port-level checks of the list engine
// Watches the request and response channels and flags responses that break
// ordering, holding or status consistency.
// ----------------------------------------------------------------------------
module blie_checker
   import blie_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [DATA_W-1:0]        rsp_result_value,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [COUNT_OUT_W-1:0]   rsp_item_count,
   input logic                     rsp_is_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_item_count))
      else $error("response changed while stalled");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response one cycle after request transfer");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_item_count == '0)
      else $error("empty flag with nonzero count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_is_empty
         && rsp_result_value == NONE_WORD)
      else $error("empty status on nonempty list or with a value");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> !rsp_is_empty
         && rsp_result_value == NONE_WORD)
      else $error("full status inconsistent");

endmodule

bind bounded_indexed_list_engine_core blie_checker u_blie_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status),
   .rsp_item_count   (rsp_item_count),
   .rsp_is_empty     (rsp_is_empty)
);
